FILE: rtl/core/dls_pkg.sv
// ----------------------------------------------------------------------------
// dls_pkg
// shared widths, codes and types of the directional light shading block
// ----------------------------------------------------------------------------
package dls_pkg;

   // fixed point formats
   localparam int NORMAL_FRAC = 8;
   localparam int GAIN_FRAC   = 8;
   localparam int ACC_FRAC    = 8;

   // field widths
   localparam int COORD_W = 16;
   localparam int COLOR_W = 8;
   localparam int BASE_W  = 24;
   localparam int GAIN_W  = 10;
   localparam int ACC_W   = 32;

   // datapath widths
   localparam int SQ_W      = 32;                       // dx^2 + dy^2 + dz^2
   localparam int DOT_W     = 34;                       // signed dot product
   localparam int MAG_W     = 32;                       // |dot|
   localparam int ROOT_W    = 32;                       // square root working value
   localparam int BIT_W     = 31;                       // square root probe bit
   localparam int LEN_W     = 16;                       // direction length
   localparam int LG_W      = COLOR_W + GAIN_W;         // light * gain
   localparam int MA_W      = LG_W + 1;                 // multiplier port a, signed
   localparam int MB_W      = MAG_W + 1;                // multiplier port b, signed
   localparam int PROD_W    = MA_W + MB_W;
   localparam int NUM_SHIFT = GAIN_FRAC + NORMAL_FRAC - ACC_FRAC;
   localparam int NUM_W     = LG_W + MAG_W - NUM_SHIFT; // dividend / quotient
   localparam int QSAT_W    = ACC_W + 2;                // clamped quotient magnitude
   localparam int CONTRIB_W = QSAT_W + 1;
   localparam int SUM_W     = CONTRIB_W + 1;
   localparam int SUB_W     = ROOT_W + 2;

   // sequencer step counts
   localparam int MUL_STEPS  = 6;
   localparam int SQRT_STEPS = 16;
   localparam int DIV_STEPS  = NUM_W;
   localparam int STEP_W     = 6;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_RED_GAIN   = 2'd0,
      REG_GREEN_GAIN = 2'd1,
      REG_BLUE_GAIN  = 2'd2
   } dls_reg_type;

   typedef enum logic [1:0] {
      CH_RED   = 2'd0,
      CH_GREEN = 2'd1,
      CH_BLUE  = 2'd2
   } dls_chan_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL  = 7'b0000010,
      ST_SQRT = 7'b0000100,
      ST_CHAN = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_ADD  = 7'b0100000,
      ST_FIN  = 7'b1000000
   } dls_state_type;

   typedef struct packed {
      logic [BASE_W-1:0]         base_color;
      logic signed [COORD_W-1:0] normal_x;
      logic signed [COORD_W-1:0] normal_y;
      logic signed [COORD_W-1:0] normal_z;
      logic [COLOR_W-1:0]        light_red;
      logic [COLOR_W-1:0]        light_green;
      logic [COLOR_W-1:0]        light_blue;
      logic signed [COORD_W-1:0] dir_x;
      logic signed [COORD_W-1:0] dir_y;
      logic signed [COORD_W-1:0] dir_z;
      logic                      light_valid;
      logic                      last_light;
      logic                      load_base;
      logic [GAIN_W-1:0]         red_gain;
      logic [GAIN_W-1:0]         green_gain;
      logic [GAIN_W-1:0]         blue_gain;
   } dls_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic emit;
   } dls_sts_type;

endpackage

FILE: rtl/core/dls_engine.sv
// ----------------------------------------------------------------------------
// dls_engine
// sequenced shading datapath: one multiplier reused for squares, dot product and
// channel products, one subtractor for square root and division, saturating accumulation
// ----------------------------------------------------------------------------
module dls_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  dls_pkg::dls_cmd_type          cmd,
   input  logic                          out_free,
   output dls_pkg::dls_sts_type          sts,
   output logic [dls_pkg::COLOR_W-1:0]   shade_red,
   output logic [dls_pkg::COLOR_W-1:0]   shade_green,
   output logic [dls_pkg::COLOR_W-1:0]   shade_blue
);

   dls_pkg::dls_state_type               state_ff, state_in;
   logic [dls_pkg::STEP_W-1:0]           step_ff, step_in;
   logic [1:0]                           ch_ff, ch_in;
   dls_pkg::dls_cmd_type                 cmd_ff, cmd_in;
   logic [dls_pkg::SQ_W-1:0]             sq_ff, sq_in;
   logic signed [dls_pkg::DOT_W-1:0]     dot_ff, dot_in;
   logic [dls_pkg::ROOT_W-1:0]           res_ff, res_in;
   logic [dls_pkg::BIT_W-1:0]            bit_ff, bit_in;
   logic signed [dls_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [dls_pkg::LEN_W-1:0]            rem_ff, rem_in;
   logic [dls_pkg::NUM_W-1:0]            num_ff, num_in;
   logic signed [dls_pkg::ACC_W-1:0]     acc_ff [3];
   logic signed [dls_pkg::ACC_W-1:0]     acc_in [3];

   logic signed [dls_pkg::MA_W-1:0]      mul_a;
   logic signed [dls_pkg::MB_W-1:0]      mul_b;
   logic [dls_pkg::SUB_W-1:0]            sub_a, sub_b, diff;
   logic                                 ge;
   logic [dls_pkg::LEN_W-1:0]            len;
   logic signed [dls_pkg::DOT_W-1:0]     dot_abs;
   logic [dls_pkg::MAG_W-1:0]            mag;
   logic [dls_pkg::COLOR_W-1:0]          light_sel;
   logic [dls_pkg::GAIN_W-1:0]           gain_sel;
   logic [dls_pkg::QSAT_W-1:0]           qsat;
   logic signed [dls_pkg::CONTRIB_W-1:0] contrib;
   logic signed [dls_pkg::SUM_W-1:0]     sum;
   logic signed [dls_pkg::ACC_W-1:0]     sat_sum;
   logic [dls_pkg::LEN_W:0]              div_shift;

   assign len       = res_ff[dls_pkg::LEN_W-1:0];
   assign dot_abs   = dot_ff[dls_pkg::DOT_W-1] ? -dot_ff : dot_ff;
   assign mag       = dot_abs[dls_pkg::MAG_W-1:0];
   assign div_shift = {rem_ff, num_ff[dls_pkg::NUM_W-1]};

   // channel operand select
   always_comb begin
      case (ch_ff)
         dls_pkg::CH_RED: begin
            light_sel = cmd_ff.light_red;
            gain_sel  = cmd_ff.red_gain;
         end
         dls_pkg::CH_GREEN: begin
            light_sel = cmd_ff.light_green;
            gain_sel  = cmd_ff.green_gain;
         end
         default: begin
            light_sel = cmd_ff.light_blue;
            gain_sel  = cmd_ff.blue_gain;
         end
      endcase
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         dls_pkg::ST_MUL: begin
            case (step_ff)
               6'd0: begin
                  mul_a = dls_pkg::MA_W'(cmd_ff.dir_x);
                  mul_b = dls_pkg::MB_W'(cmd_ff.dir_x);
               end
               6'd1: begin
                  mul_a = dls_pkg::MA_W'(cmd_ff.dir_y);
                  mul_b = dls_pkg::MB_W'(cmd_ff.dir_y);
               end
               6'd2: begin
                  mul_a = dls_pkg::MA_W'(cmd_ff.dir_z);
                  mul_b = dls_pkg::MB_W'(cmd_ff.dir_z);
               end
               6'd3: begin
                  mul_a = dls_pkg::MA_W'(cmd_ff.dir_x);
                  mul_b = dls_pkg::MB_W'(cmd_ff.normal_x);
               end
               6'd4: begin
                  mul_a = dls_pkg::MA_W'(cmd_ff.dir_y);
                  mul_b = dls_pkg::MB_W'(cmd_ff.normal_y);
               end
               6'd5: begin
                  mul_a = dls_pkg::MA_W'(cmd_ff.dir_z);
                  mul_b = dls_pkg::MB_W'(cmd_ff.normal_z);
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         dls_pkg::ST_CHAN: begin
            if (step_ff == '0) begin
               mul_a = $signed({{(dls_pkg::MA_W-dls_pkg::COLOR_W){1'b0}}, light_sel});
               mul_b = $signed({{(dls_pkg::MB_W-dls_pkg::GAIN_W){1'b0}}, gain_sel});
            end else begin
               mul_a = $signed({1'b0, prod_ff[dls_pkg::LG_W-1:0]});
               mul_b = $signed({1'b0, mag});
            end
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = dls_pkg::PROD_W'(mul_a) * dls_pkg::PROD_W'(mul_b);

   // shared subtractor: root trial and division trial
   always_comb begin
      sub_a = '0;
      sub_b = '0;
      case (state_ff)
         dls_pkg::ST_SQRT: begin
            sub_a = dls_pkg::SUB_W'(sq_ff);
            sub_b = dls_pkg::SUB_W'(res_ff) + dls_pkg::SUB_W'(bit_ff);
         end
         dls_pkg::ST_DIV: begin
            sub_a = dls_pkg::SUB_W'(div_shift);
            sub_b = dls_pkg::SUB_W'(len);
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
   end

   assign diff = sub_a - sub_b;
   assign ge   = ~diff[dls_pkg::SUB_W-1];

   // signed contribution and saturating add
   always_comb begin
      if (|num_ff[dls_pkg::NUM_W-1:dls_pkg::QSAT_W-1]) begin
         qsat = {1'b1, {(dls_pkg::QSAT_W-1){1'b0}}};
      end else begin
         qsat = num_ff[dls_pkg::QSAT_W-1:0];
      end
      if (dot_ff[dls_pkg::DOT_W-1]) begin
         contrib = -$signed({1'b0, qsat});
      end else begin
         contrib = $signed({1'b0, qsat});
      end
      sum = dls_pkg::SUM_W'(acc_ff[ch_ff]) + dls_pkg::SUM_W'(contrib);
      if (!sum[dls_pkg::SUM_W-1] && (|sum[dls_pkg::SUM_W-2:dls_pkg::ACC_W-1])) begin
         sat_sum = {1'b0, {(dls_pkg::ACC_W-1){1'b1}}};
      end else if (sum[dls_pkg::SUM_W-1] && !(&sum[dls_pkg::SUM_W-2:dls_pkg::ACC_W-1])) begin
         sat_sum = {1'b1, {(dls_pkg::ACC_W-1){1'b0}}};
      end else begin
         sat_sum = sum[dls_pkg::ACC_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ch_in    = ch_ff;
      cmd_in   = cmd_ff;
      sq_in    = sq_ff;
      dot_in   = dot_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      for (int i = 0; i < 3; i++) begin
         acc_in[i] = acc_ff[i];
      end
      case (state_ff)
         dls_pkg::ST_IDLE: begin
            if (start) begin
               cmd_in  = cmd;
               step_in = '0;
               sq_in   = '0;
               dot_in  = '0;
               if (cmd.load_base) begin
                  acc_in[dls_pkg::CH_RED]   = $signed({16'b0, cmd.base_color[7:0], 8'b0});
                  acc_in[dls_pkg::CH_GREEN] = $signed({16'b0, cmd.base_color[15:8], 8'b0});
                  acc_in[dls_pkg::CH_BLUE]  = $signed({16'b0, cmd.base_color[23:16], 8'b0});
               end
               state_in = cmd.light_valid ? dls_pkg::ST_MUL : dls_pkg::ST_FIN;
            end
         end
         dls_pkg::ST_MUL: begin
            // product of step n-1 is folded in at step n
            if (step_ff >= 6'd1 && step_ff <= 6'd3) begin
               sq_in = sq_ff + prod_ff[dls_pkg::SQ_W-1:0];
            end else if (step_ff >= 6'd4) begin
               dot_in = dot_ff + prod_ff[dls_pkg::DOT_W-1:0];
            end
            step_in = step_ff + 6'd1;
            if (step_ff == dls_pkg::STEP_W'(dls_pkg::MUL_STEPS)) begin
               step_in  = '0;
               res_in   = '0;
               bit_in   = {1'b1, {(dls_pkg::BIT_W-1){1'b0}}};
               state_in = dls_pkg::ST_SQRT;
            end
         end
         dls_pkg::ST_SQRT: begin
            if (ge) begin
               sq_in  = diff[dls_pkg::SQ_W-1:0];
               res_in = (res_ff >> 1) + dls_pkg::ROOT_W'(bit_ff);
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 6'd1;
            if (step_ff == dls_pkg::STEP_W'(dls_pkg::SQRT_STEPS - 1)) begin
               step_in  = '0;
               ch_in    = dls_pkg::CH_RED;
               // zero dot (as with zero length) leaves every channel unchanged
               state_in = (dot_ff == '0) ? dls_pkg::ST_FIN : dls_pkg::ST_CHAN;
            end
         end
         dls_pkg::ST_CHAN: begin
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd2) begin
               num_in   = prod_ff[dls_pkg::NUM_SHIFT +: dls_pkg::NUM_W];
               rem_in   = '0;
               step_in  = '0;
               state_in = dls_pkg::ST_DIV;
            end
         end
         dls_pkg::ST_DIV: begin
            rem_in  = ge ? diff[dls_pkg::LEN_W-1:0] : div_shift[dls_pkg::LEN_W-1:0];
            num_in  = {num_ff[dls_pkg::NUM_W-2:0], ge};
            step_in = step_ff + 6'd1;
            if (step_ff == dls_pkg::STEP_W'(dls_pkg::DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = dls_pkg::ST_ADD;
            end
         end
         dls_pkg::ST_ADD: begin
            acc_in[ch_ff] = sat_sum;
            if (ch_ff == dls_pkg::CH_BLUE) begin
               state_in = dls_pkg::ST_FIN;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = dls_pkg::ST_CHAN;
            end
         end
         dls_pkg::ST_FIN: begin
            if (!cmd_ff.last_light || out_free) begin
               state_in = dls_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dls_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dls_pkg::ST_IDLE;
         step_ff  <= '0;
         ch_ff    <= '0;
         for (int i = 0; i < 3; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         ch_ff    <= ch_in;
         for (int i = 0; i < 3; i++) begin
            acc_ff[i] <= acc_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      sq_ff   <= sq_in;
      dot_ff  <= dot_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
   end

   // truncate and clamp to 0..255
   function automatic logic [dls_pkg::COLOR_W-1:0] clamp_shade(
      input logic signed [dls_pkg::ACC_W-1:0] acc
   );
      logic [dls_pkg::COLOR_W-1:0] v;
      if (acc[dls_pkg::ACC_W-1]) begin
         v = '0;
      end else if (|acc[dls_pkg::ACC_W-2:dls_pkg::ACC_FRAC+dls_pkg::COLOR_W]) begin
         v = '1;
      end else begin
         v = acc[dls_pkg::ACC_FRAC +: dls_pkg::COLOR_W];
      end
      return v;
   endfunction

   assign shade_red   = clamp_shade(acc_ff[dls_pkg::CH_RED]);
   assign shade_green = clamp_shade(acc_ff[dls_pkg::CH_GREEN]);
   assign shade_blue  = clamp_shade(acc_ff[dls_pkg::CH_BLUE]);

   assign sts.busy = (state_ff != dls_pkg::ST_IDLE);
   assign sts.done = (state_ff == dls_pkg::ST_FIN);
   assign sts.emit = cmd_ff.last_light;

   // remainder stays below the divisor through the division
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == dls_pkg::ST_DIV) |-> (rem_ff < len))
      else $error("division remainder not below divisor");

   // a channel pass only starts with a nonzero direction length
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == dls_pkg::ST_CHAN) |-> (len != '0))
      else $error("channel pass with zero length");

   // base colour load leaves the red accumulator an integer value of at most 255
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == dls_pkg::ST_IDLE && start && cmd.load_base) |=>
         (acc_ff[dls_pkg::CH_RED][7:0] == '0 && acc_ff[dls_pkg::CH_RED][31:16] == '0))
      else $error("bad base colour load");

endmodule

FILE: rtl/core/directional_light_shading_top.sv
// ----------------------------------------------------------------------------
// directional_light_shading_top
// flat lambert shading of a polygon under a run of directional lights
// ----------------------------------------------------------------------------
// usage:
//   one request carries one (polygon, light) pair on the req_ channel
//   (valid/stall). the first request of a run loads the base colour; every
//   request with light_valid adds that light; the request with last_light
//   set produces one result on the rsp_ channel and closes the run.
//   gains are set over the csr_ apb port (red 0x0, green 0x4, blue 0x8)
//   while the block is idle: a user rule that the block does not enforce.
// sequencing:
//   one request at a time; req_stall is high while the engine works.
//   a valid light with nonzero dot product runs the six shared multiplies,
//   16 square root steps, then per channel the light * gain * |dot| product,
//   42 divide steps and 1 add. a light with zero dot product skips the
//   channel passes; an invalid light goes straight to the finish state.
//   the result goes to the output register once done and the slot is free.
// reset:
//   synchronous, active high; gains, run state and accumulators clear.
// stall:
//   one output register; a finished result waits there while a new request
//   is taken. a second result waits inside the engine until the slot frees.
// ----------------------------------------------------------------------------
module directional_light_shading_top (
   input  logic                                    clock,
   input  logic                                    reset,

   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [dls_pkg::BASE_W-1:0]              req_base_color,
   input  logic signed [dls_pkg::COORD_W-1:0]      req_normal_x,
   input  logic signed [dls_pkg::COORD_W-1:0]      req_normal_y,
   input  logic signed [dls_pkg::COORD_W-1:0]      req_normal_z,
   input  logic [dls_pkg::COLOR_W-1:0]             req_light_red,
   input  logic [dls_pkg::COLOR_W-1:0]             req_light_green,
   input  logic [dls_pkg::COLOR_W-1:0]             req_light_blue,
   input  logic signed [dls_pkg::COORD_W-1:0]      req_dir_x,
   input  logic signed [dls_pkg::COORD_W-1:0]      req_dir_y,
   input  logic signed [dls_pkg::COORD_W-1:0]      req_dir_z,
   input  logic                                    req_light_valid,
   input  logic                                    req_last_light,

   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [dls_pkg::COLOR_W-1:0]             rsp_shade_red,
   output logic [dls_pkg::COLOR_W-1:0]             rsp_shade_green,
   output logic [dls_pkg::COLOR_W-1:0]             rsp_shade_blue,

   // configuration port
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [dls_pkg::CSR_ADDR_W-1:0]          csr_paddr,
   input  logic [dls_pkg::CSR_DATA_W-1:0]          csr_pwdata,
   output logic [dls_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                    csr_pready
);

   logic [dls_pkg::GAIN_W-1:0]  red_gain_ff, red_gain_in;
   logic [dls_pkg::GAIN_W-1:0]  green_gain_ff, green_gain_in;
   logic [dls_pkg::GAIN_W-1:0]  blue_gain_ff, blue_gain_in;
   logic                        run_active_ff, run_active_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [dls_pkg::COLOR_W-1:0] shade_red_ff, shade_red_in;
   logic [dls_pkg::COLOR_W-1:0] shade_green_ff, shade_green_in;
   logic [dls_pkg::COLOR_W-1:0] shade_blue_ff, shade_blue_in;

   dls_pkg::dls_cmd_type        cmd;
   dls_pkg::dls_sts_type        sts;
   dls_pkg::dls_reg_type        reg_sel;
   logic                        req_take;
   logic                        csr_write;
   logic                        out_free;
   logic                        out_load;
   logic [dls_pkg::COLOR_W-1:0] eng_red, eng_green, eng_blue;

   // ---------------------------------------------------------------- csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = dls_pkg::dls_reg_type'(csr_paddr[dls_pkg::CSR_ADDR_W-1:2]);

   always_comb begin
      red_gain_in   = red_gain_ff;
      green_gain_in = green_gain_ff;
      blue_gain_in  = blue_gain_ff;
      if (csr_write) begin
         case (reg_sel)
            dls_pkg::REG_RED_GAIN:   red_gain_in   = csr_pwdata[dls_pkg::GAIN_W-1:0];
            dls_pkg::REG_GREEN_GAIN: green_gain_in = csr_pwdata[dls_pkg::GAIN_W-1:0];
            dls_pkg::REG_BLUE_GAIN:  blue_gain_in  = csr_pwdata[dls_pkg::GAIN_W-1:0];
            default: begin
               // unmapped address, write dropped
               red_gain_in = red_gain_ff;
            end
         endcase
      end
   end

   // read mux, unmapped addresses read zero
   always_comb begin
      case (reg_sel)
         dls_pkg::REG_RED_GAIN:   csr_prdata = dls_pkg::CSR_DATA_W'(red_gain_ff);
         dls_pkg::REG_GREEN_GAIN: csr_prdata = dls_pkg::CSR_DATA_W'(green_gain_ff);
         dls_pkg::REG_BLUE_GAIN:  csr_prdata = dls_pkg::CSR_DATA_W'(blue_gain_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- request side
   // engine takes one request at a time
   assign req_stall = sts.busy;
   assign req_take  = req_valid & ~sts.busy;

   // a run opens on the first request and closes on last_light
   assign run_active_in = req_take ? ~req_last_light : run_active_ff;

   always_comb begin
      cmd.base_color  = req_base_color;
      cmd.normal_x    = req_normal_x;
      cmd.normal_y    = req_normal_y;
      cmd.normal_z    = req_normal_z;
      cmd.light_red   = req_light_red;
      cmd.light_green = req_light_green;
      cmd.light_blue  = req_light_blue;
      cmd.dir_x       = req_dir_x;
      cmd.dir_y       = req_dir_y;
      cmd.dir_z       = req_dir_z;
      cmd.light_valid = req_light_valid;
      cmd.last_light  = req_last_light;
      cmd.load_base   = ~run_active_ff;
      cmd.red_gain    = red_gain_ff;
      cmd.green_gain  = green_gain_ff;
      cmd.blue_gain   = blue_gain_ff;
   end

   dls_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (req_take),
      .cmd         (cmd),
      .out_free    (out_free),
      .sts         (sts),
      .shade_red   (eng_red),
      .shade_green (eng_green),
      .shade_blue  (eng_blue)
   );

   // ---------------------------------------------------------------- result side
   // output slot is free when empty or being drained this cycle
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign out_load = sts.done & sts.emit & out_free;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      shade_red_in   = shade_red_ff;
      shade_green_in = shade_green_ff;
      shade_blue_in  = shade_blue_ff;
      if (out_load) begin
         rsp_valid_in   = 1'b1;
         shade_red_in   = eng_red;
         shade_green_in = eng_green;
         shade_blue_in  = eng_blue;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_shade_red   = shade_red_ff;
   assign rsp_shade_green = shade_green_ff;
   assign rsp_shade_blue  = shade_blue_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         red_gain_ff   <= '0;
         green_gain_ff <= '0;
         blue_gain_ff  <= '0;
         run_active_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         red_gain_ff   <= red_gain_in;
         green_gain_ff <= green_gain_in;
         blue_gain_ff  <= blue_gain_in;
         run_active_ff <= run_active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      shade_red_ff   <= shade_red_in;
      shade_green_ff <= shade_green_in;
      shade_blue_ff  <= shade_blue_in;
   end

   // a finished result blocked by a stalled output keeps the request side closed
   assert property (@(posedge clock) disable iff (reset)
      (sts.done && sts.emit && rsp_valid_ff && rsp_stall) |=> req_stall)
      else $error("result dropped while output stalled");

   // a stalled result stays valid
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("result lost while stalled");

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=>
         $stable({shade_red_ff, shade_green_ff, shade_blue_ff}))
      else $error("result payload changed while stalled");

endmodule

FILE: tb/directional_light_shading_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// directional_light_shading_top_tb
// self-checking bench for flat lambert shading under directional lights
// ----------------------------------------------------------------------------
// a queue of (polygon, light) requests feeds a clocked driver; a clocked
// monitor computes the expected shade of every accepted run in fixed point
// and compares each result on the rsp_ channel, channel by channel. gains
// are rewritten over the csr_ port between phases while the block is idle.
// phases vary sender idling, receiver stalling and a long receiver hold-off.
// ----------------------------------------------------------------------------
module directional_light_shading_top_tb;

   localparam int CYCLE_LIMIT   = 1000000;  // generous cap on the whole run
   localparam int SETTLE_CYCLES = 400;      // covers a light still in the engine
   localparam int HOLD_CYCLES   = 30000;    // long receiver hold-off, past two longest runs
   localparam int PHASE_ITEMS   = 260;      // at least this many random requests per phase
   localparam int NUM_PHASES    = 4;
   localparam int NUM_CHAN      = 3;
   localparam int SAT_LIGHTS    = 40;       // enough strong lights to saturate
   localparam logic [1:0] UNUSED_REG = 2'd3; // address with no register behind it

   typedef struct packed {
      logic [dls_pkg::BASE_W-1:0]         base_color;
      logic signed [dls_pkg::COORD_W-1:0] normal_x;
      logic signed [dls_pkg::COORD_W-1:0] normal_y;
      logic signed [dls_pkg::COORD_W-1:0] normal_z;
      logic [dls_pkg::COLOR_W-1:0]        light_red;
      logic [dls_pkg::COLOR_W-1:0]        light_green;
      logic [dls_pkg::COLOR_W-1:0]        light_blue;
      logic signed [dls_pkg::COORD_W-1:0] dir_x;
      logic signed [dls_pkg::COORD_W-1:0] dir_y;
      logic signed [dls_pkg::COORD_W-1:0] dir_z;
      logic                               light_valid;
      logic                               last_light;
   } light_req_type;

   // index 0 red, 1 green, 2 blue
   typedef logic [NUM_CHAN-1:0][dls_pkg::COLOR_W-1:0] shade_type;

   logic clock = 1'b0;
   logic reset;

   logic                               req_valid;
   logic                               req_stall;
   logic [dls_pkg::BASE_W-1:0]         req_base_color;
   logic signed [dls_pkg::COORD_W-1:0] req_normal_x;
   logic signed [dls_pkg::COORD_W-1:0] req_normal_y;
   logic signed [dls_pkg::COORD_W-1:0] req_normal_z;
   logic [dls_pkg::COLOR_W-1:0]        req_light_red;
   logic [dls_pkg::COLOR_W-1:0]        req_light_green;
   logic [dls_pkg::COLOR_W-1:0]        req_light_blue;
   logic signed [dls_pkg::COORD_W-1:0] req_dir_x;
   logic signed [dls_pkg::COORD_W-1:0] req_dir_y;
   logic signed [dls_pkg::COORD_W-1:0] req_dir_z;
   logic                               req_light_valid;
   logic                               req_last_light;

   logic                               rsp_valid;
   logic                               rsp_stall;
   logic [dls_pkg::COLOR_W-1:0]        rsp_shade_red;
   logic [dls_pkg::COLOR_W-1:0]        rsp_shade_green;
   logic [dls_pkg::COLOR_W-1:0]        rsp_shade_blue;

   logic                               csr_psel;
   logic                               csr_penable;
   logic                               csr_pwrite;
   logic [dls_pkg::CSR_ADDR_W-1:0]     csr_paddr;
   logic [dls_pkg::CSR_DATA_W-1:0]     csr_pwdata;
   logic [dls_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                               csr_pready;

   // stimulus and expectation stores
   light_req_type pending_lights [$];
   shade_type     expected_shades [$];
   light_req_type offered;       // request currently on the req_ channel
   logic          req_taken;     // request accepted at the last rising edge

   // shading model state, kept by the monitor
   logic [dls_pkg::GAIN_W-1:0]       gain_reg [NUM_CHAN];
   logic                             run_open;
   logic signed [dls_pkg::ACC_W-1:0] shade_acc [NUM_CHAN];

   // phase controls, set by the sequence
   int  send_idle_pct;
   int  recv_stall_pct;
   logic holdoff_armed;
   logic holdoff_done;
   int  hold_left;

   int  queued_count;
   int  accepted_count;
   int  result_count;
   int  mismatch_count;
   int  cycle_count;

   string chan_name [NUM_CHAN] = '{"red", "green", "blue"};

   directional_light_shading_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_base_color  (req_base_color),
      .req_normal_x    (req_normal_x),
      .req_normal_y    (req_normal_y),
      .req_normal_z    (req_normal_z),
      .req_light_red   (req_light_red),
      .req_light_green (req_light_green),
      .req_light_blue  (req_light_blue),
      .req_dir_x       (req_dir_x),
      .req_dir_y       (req_dir_y),
      .req_dir_z       (req_dir_z),
      .req_light_valid (req_light_valid),
      .req_last_light  (req_last_light),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_shade_red   (rsp_shade_red),
      .rsp_shade_green (rsp_shade_green),
      .rsp_shade_blue  (rsp_shade_blue),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // fixed point shading model
   // ------------------------------------------------------------------------

   // integer square root, floor
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v    = v - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // light * gain * dot / |dir|, scaled to 8 fraction bits, truncated to zero
   function automatic longint light_term(input longint unsigned intensity,
                                         input longint unsigned gain,
                                         input longint dot,
                                         input longint unsigned len);
      longint unsigned mag;
      longint unsigned quot;
      if (len == 0 || dot == 0) return 0;
      mag  = (dot < 0) ? longint'(-dot) : longint'(dot);
      mag  = intensity * gain * mag * 256;
      quot = mag / (len << (dls_pkg::GAIN_FRAC + dls_pkg::NORMAL_FRAC));
      return (dot < 0) ? -longint'(quot) : longint'(quot);
   endfunction

   function automatic logic signed [dls_pkg::ACC_W-1:0] acc_saturate(
         input logic signed [dls_pkg::ACC_W-1:0] acc, input longint add);
      longint sum;
      sum = longint'(acc) + add;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      return sum[dls_pkg::ACC_W-1:0];
   endfunction

   function automatic logic [dls_pkg::COLOR_W-1:0] shade_clamp(
         input logic signed [dls_pkg::ACC_W-1:0] acc);
      logic signed [dls_pkg::ACC_W-1:0] whole;
      if (acc < 0) return '0;
      whole = acc >>> dls_pkg::ACC_FRAC;
      return (whole > 255) ? 8'd255 : whole[dls_pkg::COLOR_W-1:0];
   endfunction

   // append one request to the stimulus queue
   task automatic queue_light(input light_req_type it);
      pending_lights.insert(pending_lights.size(), it);
   endtask

   // fold one accepted request into the accumulators, queue the shade on last
   task automatic shade_accumulate(input light_req_type it);
      longint          dx, dy, dz, dot;
      longint unsigned len;
      logic [dls_pkg::COLOR_W-1:0] intensity [NUM_CHAN];
      shade_type       shade;
      intensity[dls_pkg::CH_RED]   = it.light_red;
      intensity[dls_pkg::CH_GREEN] = it.light_green;
      intensity[dls_pkg::CH_BLUE]  = it.light_blue;
      // first request of a run loads the base colour
      if (!run_open) begin
         for (int c = 0; c < NUM_CHAN; c++)
            shade_acc[c] = {16'd0, it.base_color[8*c +: 8], 8'd0};
      end
      if (it.light_valid) begin
         dx  = it.dir_x;
         dy  = it.dir_y;
         dz  = it.dir_z;
         len = int_sqrt(longint'(dx * dx + dy * dy + dz * dz));
         dot = dx * longint'(it.normal_x) + dy * longint'(it.normal_y)
               + dz * longint'(it.normal_z);
         for (int c = 0; c < NUM_CHAN; c++)
            shade_acc[c] = acc_saturate(shade_acc[c],
                                        light_term(intensity[c], gain_reg[c], dot, len));
      end
      if (it.last_light) begin
         for (int c = 0; c < NUM_CHAN; c++) shade[c] = shade_clamp(shade_acc[c]);
         expected_shades.insert(expected_shades.size(), shade);
         run_open = 1'b0;
      end else begin
         run_open = 1'b1;
      end
   endtask

   // ------------------------------------------------------------------------
   // request driver: changes on the falling edge, holds while stalled
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         // slot free: present the next request unless the sender idles
         if (pending_lights.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            offered = pending_lights.pop_front();
            req_valid       <= 1'b1;
            req_base_color  <= offered.base_color;
            req_normal_x    <= offered.normal_x;
            req_normal_y    <= offered.normal_y;
            req_normal_z    <= offered.normal_z;
            req_light_red   <= offered.light_red;
            req_light_green <= offered.light_green;
            req_light_blue  <= offered.light_blue;
            req_dir_x       <= offered.dir_x;
            req_dir_y       <= offered.dir_y;
            req_dir_z       <= offered.dir_z;
            req_light_valid <= offered.light_valid;
            req_last_light  <= offered.last_light;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver stall, with a one-time long hold-off counted here
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (holdoff_armed && !holdoff_done) begin
            hold_left    = HOLD_CYCLES;
            holdoff_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: samples both channels on the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      shade_type got;
      shade_type want;
      req_taken = 1'b0;
      if (!reset) begin
         // accepted request feeds the shading model
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            accepted_count++;
            shade_accumulate(offered);
         end
         // accepted result is checked against the oldest expectation
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            got = {rsp_shade_blue, rsp_shade_green, rsp_shade_red};
            result_count++;
            if (expected_shades.size() == 0) begin
               mismatch_count++;
               $display("%0t: shade result with none expected: expected none, actual %0d %0d %0d",
                        $time, got[dls_pkg::CH_RED], got[dls_pkg::CH_GREEN],
                        got[dls_pkg::CH_BLUE]);
            end else begin
               want = expected_shades.pop_front();
               for (int c = 0; c < NUM_CHAN; c++) begin
                  if (got[c] !== want[c]) begin
                     mismatch_count++;
                     $display("%0t: shade_%s expected %0d, actual %0d",
                              $time, chan_name[c], want[c], got[c]);
                  end
               end
            end
         end
      end
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d shades still expected",
                  cycle_count, expected_shades.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // sequence helpers
   // ------------------------------------------------------------------------

   // apb write: setup cycle, then access cycle until pready
   task automatic write_gain(input logic [1:0] reg_index,
                             input logic [dls_pkg::GAIN_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= dls_pkg::CSR_ADDR_W'({reg_index, 2'b00});
      csr_pwdata  <= dls_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      // an address past the last gain register changes nothing
      if (reg_index != UNUSED_REG) gain_reg[reg_index] = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic write_gains(input logic [dls_pkg::GAIN_W-1:0] red,
                              input logic [dls_pkg::GAIN_W-1:0] green,
                              input logic [dls_pkg::GAIN_W-1:0] blue);
      write_gain(dls_pkg::REG_RED_GAIN, red);
      write_gain(dls_pkg::REG_GREEN_GAIN, green);
      write_gain(dls_pkg::REG_BLUE_GAIN, blue);
   endtask

   // wait until every request went in and every shade came out, then let
   // a light with no result finish inside the engine
   task automatic wait_idle();
      while (pending_lights.size() != 0 || req_valid || expected_shades.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic light_req_type make_req(
         input logic [23:0] base, input logic [15:0] nx, input logic [15:0] ny,
         input logic [15:0] nz, input logic [7:0] lr, input logic [7:0] lg,
         input logic [7:0] lb, input logic [15:0] dx, input logic [15:0] dy,
         input logic [15:0] dz, input logic valid, input logic last);
      light_req_type it;
      it = '{base, nx, ny, nz, lr, lg, lb, dx, dy, dz, valid, last};
      return it;
   endfunction

   function automatic logic [15:0] pick_coord();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 45) return 16'($urandom_range(65535));
      if (sel < 85) return 16'(int'($urandom_range(600)) - 300);
      case ($urandom_range(3))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         default: return 16'hffff;
      endcase
   endfunction

   task automatic queue_run(input int lights, input logic saturating);
      light_req_type it;
      logic [23:0]   base;
      logic [15:0]   nx, ny, nz;
      logic [15:0]   ext_n, ext_d;
      base = 24'($urandom);
      nx   = pick_coord();
      ny   = pick_coord();
      nz   = pick_coord();
      // saturating run: extreme normal and direction, aligned or opposed
      ext_n = $urandom_range(1) ? 16'h8000 : 16'h7fff;
      ext_d = $urandom_range(1) ? ext_n : ~ext_n;
      for (int i = 0; i < lights; i++) begin
         if (saturating) begin
            it = make_req(base, ext_n, ext_n, ext_n, 8'd255, 8'd255, 8'd255,
                          ext_d, ext_d, ext_d, 1'b1, 1'b0);
         end else begin
            it = make_req(base, nx, ny, nz, 8'($urandom), 8'($urandom), 8'($urandom),
                          pick_coord(), pick_coord(), pick_coord(),
                          $urandom_range(99) < 85, 1'b0);
            if ($urandom_range(99) < 4) begin
               it.dir_x = '0;
               it.dir_y = '0;
               it.dir_z = '0;
            end
         end
         // base on later requests is ignored; scramble it now and then
         if (i != 0 && $urandom_range(9) == 0) it.base_color = 24'($urandom);
         it.last_light = (i == lights - 1);
         queue_light(it);
      end
      queued_count += lights;
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin : sequence_main
      int target;
      int pick;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_base_color  = '0;
      req_normal_x    = '0;
      req_normal_y    = '0;
      req_normal_z    = '0;
      req_light_red   = '0;
      req_light_green = '0;
      req_light_blue  = '0;
      req_dir_x       = '0;
      req_dir_y       = '0;
      req_dir_z       = '0;
      req_light_valid = 1'b0;
      req_last_light  = 1'b0;
      rsp_stall       = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      req_taken       = 1'b0;
      run_open        = 1'b0;
      holdoff_armed   = 1'b0;
      holdoff_done    = 1'b0;
      hold_left       = 0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      queued_count    = 0;
      accepted_count  = 0;
      result_count    = 0;
      mismatch_count  = 0;
      cycle_count     = 0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         gain_reg[c]  = '0;
         shade_acc[c] = '0;
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part: full, zero and unity gains, plus a write to no register
      write_gains(10'd1023, 10'd0, 10'd256);
      write_gain(UNUSED_REG, 10'h3ff);

      // single-request runs with no light keep the base colour
      queue_light(make_req(24'hffffff, 16'h0100, 16'd0, 16'd0, 8'd255, 8'd255, 8'd255,
                           16'h0100, 16'd0, 16'd0, 1'b0, 1'b1));
      queue_light(make_req(24'h000000, 16'h0100, 16'd0, 16'd0, 8'd255, 8'd255, 8'd255,
                           16'h0100, 16'd0, 16'd0, 1'b0, 1'b1));
      // zero-length direction adds nothing
      queue_light(make_req(24'h804020, 16'h7fff, 16'h7fff, 16'h7fff,
                           8'd255, 8'd255, 8'd255, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
      // extreme vectors aligned, opposed, then aligned again
      queue_light(make_req(24'h102030, 16'h8000, 16'h8000, 16'h8000,
                           8'd255, 8'd255, 8'd255,
                           16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b1));
      queue_light(make_req(24'hf0e0d0, 16'h8000, 16'h8000, 16'h8000,
                           8'd255, 8'd255, 8'd255,
                           16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 1'b1));
      queue_light(make_req(24'h000000, 16'h7fff, 16'h7fff, 16'h7fff,
                           8'd255, 8'd255, 8'd255,
                           16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 1'b1));
      // perpendicular light: zero dot product
      queue_light(make_req(24'h404040, 16'h0100, 16'd0, 16'd0, 8'd200, 8'd200, 8'd200,
                           16'd0, 16'd100, 16'd0, 1'b1, 1'b1));
      // multi-light run: invalid first still loads the base, later base ignored
      queue_light(make_req(24'h202020, 16'h0100, 16'h0080, 16'hff00,
                           8'd0, 8'd0, 8'd0, 16'd3, 16'd4, 16'd0, 1'b0, 1'b0));
      queue_light(make_req(24'hffffff, 16'h0100, 16'h0080, 16'hff00,
                           8'd128, 8'd64, 8'd255, 16'd3, 16'd4, 16'd0, 1'b1, 1'b0));
      queue_light(make_req(24'h000000, 16'h0100, 16'h0080, 16'hff00,
                           8'd255, 8'd0, 8'd17, 16'hfffd, 16'd0, 16'd9,
                           1'b1, 1'b0));
      // last request carries no light
      queue_light(make_req(24'h123456, 16'h0100, 16'h0080, 16'hff00,
                           8'd255, 8'd255, 8'd255, 16'd1, 16'd1, 16'd1,
                           1'b0, 1'b1));
      // small direction, negative contribution pulls below zero
      queue_light(make_req(24'h010101, 16'hff00, 16'hff00, 16'hff00,
                           8'd255, 8'd255, 8'd255, 16'd1, 16'd1, 16'd1,
                           1'b1, 1'b1));
      // dark light leaves the base untouched
      queue_light(make_req(24'h7f7f7f, 16'h0100, 16'h0100, 16'h0100,
                           8'd0, 8'd0, 8'd0, 16'd1, 16'd1, 16'd1, 1'b1, 1'b1));
      queued_count += 13;
      wait_idle();

      // random phases: each with its own gains and idling mix
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin
               write_gains(10'd1023, 10'd1023, 10'd1023);
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               // receiver holds off while the sender keeps offering
               holdoff_armed  = 1'b1;
            end
            1: begin
               write_gains(10'd0, 10'd1023, 10'd1);
               send_idle_pct  = 81;
               recv_stall_pct = 0;
            end
            2: begin
               write_gains(10'($urandom), 10'($urandom), 10'($urandom));
               send_idle_pct  = 0;
               recv_stall_pct = 81;
            end
            default: begin
               write_gains(10'd256, 10'd512, 10'd768);
               send_idle_pct  = 20;
               recv_stall_pct = 20;
            end
         endcase
         target = queued_count + PHASE_ITEMS;
         while (queued_count < target) begin
            pick = $urandom_range(99);
            if (pick < 3) queue_run(SAT_LIGHTS, 1'b1);
            else if (pick < 70) queue_run($urandom_range(1, 4), 1'b0);
            else queue_run($urandom_range(5, 10), 1'b0);
         end
         wait_idle();
      end

      $display("covered %0d requests and %0d shaded results over %0d phases",
               accepted_count, result_count, NUM_PHASES + 1);
      $display("gain extremes, saturating runs, idle and stall mixes, one long hold-off");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
